/* rtl/core/stbs_pkg.sv */
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types and constants for the sorted-table binary search block.
// ----------------------------------------------------------------------------
package stbs_pkg;

    localparam int DEF_TABLE_DEPTH = 16;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam int LEN_W   = 5;   // table_length register
    localparam int FIELD_W = 32;  // entry_value and search_key fields
    localparam int IDXF_W  = 4;   // entry_index and found_index fields

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;         // write one table entry
        logic init;         // capture key, set bounds
        logic rd;           // read entry at midpoint
        logic narrow_high;  // key below entry: upper bound to midpoint
        logic narrow_low;   // key above entry: lower bound past midpoint
        logic set_hit;      // record a match
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic range_empty;
        logic key_lt;
        logic key_eq;
    } t_dp_status;

endpackage

/* rtl/core/stbs_dpath.sv */
// ----------------------------------------------------------------------------
// stbs_dpath
// Table memory, search bounds, key register and comparator.
// ----------------------------------------------------------------------------
module stbs_dpath
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    output t_dp_status                o_status,
    input  logic                      i_cfg_valid,
    input  logic [LEN_W-1:0]          i_cfg_data,
    input  logic [IDXF_W-1:0]         i_entry_index,
    input  logic signed [FIELD_W-1:0] i_entry_value,
    input  logic signed [FIELD_W-1:0] i_search_key,
    output logic                      o_found,
    output logic [IDXF_W-1:0]         o_found_index
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int DEP_W = $clog2(TABLE_DEPTH + 1);
    localparam int CW    = (DEP_W > LEN_W) ? DEP_W : LEN_W;

    logic [VALUE_WIDTH-1:0] r_mem [TABLE_DEPTH];
    logic [LEN_W-1:0]       r_table_length;
    logic [CW-1:0]          r_low;
    logic [CW-1:0]          r_hi;     // exclusive upper bound
    logic [IDX_W-1:0]       r_mid;
    logic [VALUE_WIDTH-1:0] r_key;
    logic [VALUE_WIDTH-1:0] r_rd;
    logic                   r_hit;

    logic signed [63:0]     entry_ext;
    logic signed [63:0]     key_ext;
    logic [IDX_W+IDXF_W-1:0] wa_ext;
    logic [IDX_W-1:0]       wa;
    logic                   wa_ok;
    logic [CW-1:0]          len_ext;
    logic [CW-1:0]          len_sat;
    logic [CW:0]            msum;
    logic [CW-1:0]          mfull;
    logic [IDX_W-1:0]       mid;
    logic [IDX_W+IDXF_W-1:0] mid_ext;

    assign entry_ext = 64'(i_entry_value);
    assign key_ext   = 64'(i_search_key);
    assign wa_ext    = (IDX_W + IDXF_W)'(i_entry_index);
    assign wa        = wa_ext[IDX_W-1:0];
    assign wa_ok     = 32'(i_entry_index) < 32'(TABLE_DEPTH);
    assign len_ext   = CW'(r_table_length);
    assign len_sat   = (len_ext > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : len_ext;
    assign msum      = {1'b0, r_low} + {1'b0, r_hi} - (CW + 1)'(1);
    assign mfull     = msum[CW:1];
    assign mid       = mfull[IDX_W-1:0];
    assign mid_ext   = (IDX_W + IDXF_W)'(r_mid);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && wa_ok) begin
            r_mem[wa] <= entry_ext[VALUE_WIDTH-1:0];
        end
        if (i_cmd.rd) begin
            r_rd  <= r_mem[mid];
            r_mid <= mid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_length <= '0;
        end else if (i_cfg_valid) begin
            r_table_length <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_key <= key_ext[VALUE_WIDTH-1:0];
            r_low <= '0;
            r_hi  <= len_sat;
            r_hit <= 1'b0;
        end else begin
            if (i_cmd.narrow_high) begin
                r_hi <= CW'(r_mid);
            end
            if (i_cmd.narrow_low) begin
                r_low <= CW'(r_mid) + CW'(1);
            end
            if (i_cmd.set_hit) begin
                r_hit <= 1'b1;
            end
        end
    end

    assign o_status.range_empty = r_low >= r_hi;
    assign o_status.key_lt      = $signed(r_key) < $signed(r_rd);
    assign o_status.key_eq      = r_key == r_rd;

    assign o_found       = r_hit;
    assign o_found_index = r_hit ? mid_ext[IDXF_W-1:0] : '0;

endmodule

/* rtl/core/stbs_ctrl.sv */
// ----------------------------------------------------------------------------
// stbs_ctrl
// Sequencer for table loads and binary search probes.
// ----------------------------------------------------------------------------
module stbs_ctrl
    import stbs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic       i_operation,
    output logic       busy,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_result_valid
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_CMP  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_operation == OP_SEARCH) begin
                        o_cmd.init = 1'b1;
                        n_state    = S_READ;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_READ: begin
                if (i_status.range_empty) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_CMP;
                end
            end
            S_CMP: begin
                if (i_status.key_eq) begin
                    o_cmd.set_hit = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    // drop the half that cannot hold the key
                    o_cmd.narrow_high = i_status.key_lt;
                    o_cmd.narrow_low  = !i_status.key_lt;
                    n_state           = S_READ;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy           = r_state != S_IDLE;
    assign o_result_valid = r_state == S_DONE;

    a_cmp_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> $past(o_cmd.rd))
        else $error("compare without a preceding table read");

    a_search_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operation == OP_SEARCH) |=> (r_state == S_READ))
        else $error("search request did not start a probe");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operation == OP_LOAD) |=> (!busy && !o_result_valid))
        else $error("load request produced a result or stalled");

    a_result_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid && !busy)
        else $error("result strobe longer than one cycle");

endmodule

/* rtl/core/sorted_table_binary_search.sv */
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// Sorted table of signed values with binary search lookup.
// ----------------------------------------------------------------------------
// Load request: written at the accepting edge, no result. Search request:
// each probe reads the midpoint, then compares on the registered read; busy
// stays high through the probes, a final read that finds the range empty if
// no entry matches, and the done state. The result strobe is the last busy
// cycle; the receiver cannot stall it; the next request is taken after it.
// Synchronous reset clears table_length and the sequencer, not the table.
module sorted_table_binary_search
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_operation,
    input  logic [IDXF_W-1:0]         i_entry_index,
    input  logic signed [FIELD_W-1:0] i_entry_value,
    input  logic signed [FIELD_W-1:0] i_search_key,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [LEN_W-1:0]          i_cfg_data,
    output logic                      o_result_valid,
    output logic                      o_found,
    output logic [IDXF_W-1:0]         o_found_index
);

    t_dp_cmd    cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    stbs_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_operation    (i_operation),
        .busy           (busy),
        .i_status       (status),
        .o_cmd          (cmd),
        .o_result_valid (o_result_valid)
    );

    stbs_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .i_search_key  (i_search_key),
        .o_found       (o_found),
        .o_found_index (o_found_index)
    );

endmodule

/* tb/sorted_table_binary_search_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_binary_search_tb
// Self-checking bench for the sorted-table binary search block. It loads
// sorted tables with random content, searches under several table lengths,
// and checks every result against a local search predictor.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_tb;
    import stbs_pkg::*;

    localparam int DEPTH         = DEF_TABLE_DEPTH;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int ITEM_TARGET   = 1750;
    localparam int REPORT_MAX    = 10;

    localparam logic signed [FIELD_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic signed [FIELD_W-1:0] VAL_MAX = 32'h7fff_ffff;

    typedef struct packed {
        logic              found;
        logic [IDXF_W-1:0] index;
    } search_hit_t;

    class search_scoreboard;
        logic signed [FIELD_W-1:0] entries [DEPTH];
        logic [LEN_W-1:0]          length_reg = '0;
        search_hit_t               expected_hits [$];
        int                        mismatches = 0;

        function void flag(string msg);
            if (mismatches < REPORT_MAX) begin
                $display("%0t: %s", $realtime, msg);
            end
            mismatches++;
        endfunction

        function void set_length(logic [LEN_W-1:0] value);
            length_reg = value;
        endfunction

        function int active_length();
            return (length_reg > DEPTH) ? DEPTH : int'(length_reg);
        endfunction

        // Apply a load, or run the search and queue its outcome.
        function void note_request(logic op, logic [IDXF_W-1:0] idx,
                                   logic signed [FIELD_W-1:0] value,
                                   logic signed [FIELD_W-1:0] key);
            int          lo;
            int          hi;
            int          mid;
            search_hit_t hit;
            if (op == OP_LOAD) begin
                entries[idx] = value;
            end else begin
                hit = '0;
                lo  = 0;
                hi  = active_length() - 1;
                while (lo <= hi) begin
                    mid = (lo + hi) / 2;
                    if (key < entries[mid]) begin
                        hi = mid - 1;
                    end else if (key > entries[mid]) begin
                        lo = mid + 1;
                    end else begin
                        hit.found = 1'b1;
                        hit.index = mid[IDXF_W-1:0];
                        break;
                    end
                end
                expected_hits.push_back(hit);
            end
        endfunction

        function void check_result(logic found, logic [IDXF_W-1:0] index);
            search_hit_t want;
            if (expected_hits.size() == 0) begin
                flag($sformatf("unexpected result found=%b index=%0d", found, index));
            end else begin
                want = expected_hits.pop_front();
                if (found !== want.found || index !== want.index) begin
                    flag($sformatf({"result mismatch: expected found=%b index=%0d,",
                                    " got found=%b index=%0d"},
                                   want.found, want.index, found, index));
                end
            end
        endfunction

        function int pending();
            return expected_hits.size();
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic                      i_operation = OP_LOAD;
    logic [IDXF_W-1:0]         i_entry_index = '0;
    logic signed [FIELD_W-1:0] i_entry_value = '0;
    logic signed [FIELD_W-1:0] i_search_key = '0;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [LEN_W-1:0]          i_cfg_data = '0;
    logic                      o_result_valid;
    logic                      o_found;
    logic [IDXF_W-1:0]         o_found_index;

    search_scoreboard sb = new();
    int               items_sent = 0;
    int               cycle_count = 0;

    sorted_table_binary_search DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_entry_index  (i_entry_index),
        .i_entry_value  (i_entry_value),
        .i_search_key   (i_search_key),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_found        (o_found),
        .o_found_index  (o_found_index)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_result_valid === 1'b1) begin
            sb.check_result(o_found, o_found_index);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Present one request and hold it until the block takes it.
    task automatic send_request(input logic op, input logic [IDXF_W-1:0] idx,
                                input logic signed [FIELD_W-1:0] value,
                                input logic signed [FIELD_W-1:0] key);
        @(negedge i_clk);
        start         <= 1'b1;
        i_operation   <= op;
        i_entry_index <= idx;
        i_entry_value <= value;
        i_search_key  <= key;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_request(op, idx, value, key);
        items_sent++;
    endtask

    task automatic pause(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            start        <= 1'b0;
            i_search_key <= $urandom;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Drop start and wait for every outstanding search to report.
    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending() != 0 || busy !== 1'b0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_length(input logic [LEN_W-1:0] value);
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        sb.set_length(value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic int random_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70) return 0;
        if (sel < 90) return $urandom_range(1, 3);
        if (sel < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Fill all entries in ascending order: dense with duplicates, spread
    // over the full range, or moderate steps.
    task automatic load_sorted_table(input bit no_idle);
        longint                    acc;
        longint                    step_max;
        int                        mode;
        logic signed [FIELD_W-1:0] value;
        mode = $urandom_range(0, 2);
        case (mode)
            0: begin
                acc      = longint'($signed($urandom));
                step_max = 2;
            end
            1: begin
                acc      = longint'(VAL_MIN) + $urandom_range(0, 1 << 20);
                step_max = 1 << 28;
            end
            default: begin
                acc      = longint'($signed($urandom) >>> 4);
                step_max = 1 << 16;
            end
        endcase
        for (int i = 0; i < DEPTH; i++) begin
            if (acc > 2147483647) acc = 2147483647;
            value = (mode == 1 && i == DEPTH - 1) ? VAL_MAX : acc[FIELD_W-1:0];
            send_request(OP_LOAD, i[IDXF_W-1:0], value, $urandom);
            pause(no_idle ? 0 : random_gap());
            acc += $urandom_range(0, step_max);
        end
    endtask

    // Mostly keys that sit in the searched range, then near misses,
    // extremes and raw random values.
    function automatic logic signed [FIELD_W-1:0] pick_key();
        int sel;
        int span;
        int k;
        span = sb.active_length();
        if (span == 0) span = DEPTH;
        k   = $urandom_range(0, span - 1);
        sel = $urandom_range(0, 9);
        if (sel < 5) return sb.entries[k];
        if (sel < 7) return $urandom_range(0, 1) ? sb.entries[k] + 32'sd1
                                                 : sb.entries[k] - 32'sd1;
        if (sel == 7) begin
            case ($urandom_range(0, 3))
                0:       return VAL_MIN;
                1:       return VAL_MAX;
                2:       return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        return $urandom;
    endfunction

    initial begin
        logic signed [FIELD_W-1:0] value;
        logic [LEN_W-1:0]          len_choice;
        int                        phase;
        int                        n_items;
        bit                        no_idle;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty table right after reset: no entry is read.
        send_request(OP_SEARCH, '0, '0, 32'sd0);

        for (int i = 0; i < DEPTH; i++) begin
            if (i == 0)              value = VAL_MIN;
            else if (i == DEPTH - 1) value = VAL_MAX;
            else if (i == 7)         value = -32'sd1;
            else if (i == 9)         value = 32'sd1;
            else                     value = (i - 8) * 1000;
            send_request(OP_LOAD, i[IDXF_W-1:0], value, $urandom);
            pause(random_gap());
        end

        write_length(LEN_W'(DEPTH));
        send_request(OP_SEARCH, '0, '0, VAL_MIN);
        send_request(OP_SEARCH, '0, '0, VAL_MAX);
        send_request(OP_SEARCH, '0, '0, -32'sd1);
        send_request(OP_SEARCH, '0, '0, 32'sd500);

        // Length above the table depth saturates.
        write_length('1);
        send_request(OP_SEARCH, '0, '0, VAL_MAX);
        send_request(OP_SEARCH, '0, '0, 32'sd5);

        write_length(LEN_W'(1));
        send_request(OP_SEARCH, '0, '0, VAL_MIN);
        send_request(OP_SEARCH, '0, '0, 32'sd0);

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            case (phase)
                0:       len_choice = LEN_W'(0);
                1:       len_choice = LEN_W'(1);
                2:       len_choice = LEN_W'(2);
                3:       len_choice = LEN_W'(DEPTH);
                4:       len_choice = '1;
                5:       len_choice = LEN_W'(DEPTH + 1);
                default: len_choice = LEN_W'($urandom_range(0, (1 << LEN_W) - 1));
            endcase
            no_idle = ($urandom_range(0, 3) == 0);
            write_length(len_choice);
            if (phase == 0 || $urandom_range(0, 2) != 0) begin
                load_sorted_table(no_idle);
            end
            n_items = $urandom_range(40, 120);
            repeat (n_items) begin
                if ($urandom_range(0, 9) == 0) begin
                    // stray load: may break the ascending order
                    send_request(OP_LOAD, IDXF_W'($urandom), $urandom, $urandom);
                end else begin
                    send_request(OP_SEARCH, IDXF_W'($urandom), $urandom, pick_key());
                end
                pause(no_idle ? 0 : random_gap());
                if ($urandom_range(0, 63) == 0) wait_drained();
            end
            phase++;
        end

        wait_drained();
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
